// ----- design/sdbd_pkg.sv -----
`timescale 1ns / 1ps

package sdbd_pkg;

    // parser phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_HDR   = 3'd1;
    localparam logic [2:0] PH_FIRST = 3'd2;
    localparam logic [2:0] PH_DELTA = 3'd3;
    localparam logic [2:0] PH_SKIP  = 3'd4;

    // delta size codes
    localparam logic [2:0] SZ_NIBBLE = 3'd0;
    localparam logic [2:0] SZ_BYTE   = 3'd1;
    localparam logic [2:0] SZ_WORD   = 3'd2;

    // header byte positions
    localparam logic [13:0] POS_CHAN_HI = 14'd0;
    localparam logic [13:0] POS_CHAN_LO = 14'd1;
    localparam logic [13:0] POS_FLAGS   = 14'd2;
    localparam logic [13:0] POS_FIRST_LAST = 14'd7;

    localparam logic [31:0] FOLD_LO_MASK = 32'h0000FFFF;
    localparam logic [31:0] FOLD_HI_SET  = 32'hFFFF0000;

    localparam logic STAT_OK  = 1'b0;
    localparam logic STAT_BAD = 1'b1;

    localparam int CFG_AMP_MIN = 0;
    localparam int CFG_AMP_MAX = 1;

    typedef struct packed {
        logic [15:0] channel_id;
        logic [31:0] sample_value;
        logic [11:0] rate_value;
        logic [11:0] sample_index;
        logic        last_sample;
        logic        status;
    } t_result;

    // up to two results produced by one input item
    typedef struct packed {
        t_result     res0;
        t_result     res1;
        logic [1:0]  cnt;
    } t_batch;

endpackage

// ----- design/sdbd_core.sv -----
`timescale 1ns / 1ps

module sdbd_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [7:0]           i_byte,
    input  logic                 i_start,
    input  logic signed [31:0]   i_amp_min,
    input  logic signed [31:0]   i_amp_max,
    output sdbd_pkg::t_batch     o_batch
);

    logic [2:0]  r_phase,  n_phase;
    logic [13:0] r_bcnt,   n_bcnt;
    logic [13:0] r_glen,   n_glen;
    logic [15:0] r_chan,   n_chan;
    logic [11:0] r_rate,   n_rate;
    logic [2:0]  r_size,   n_size;
    logic [31:0] r_prev,   n_prev;
    logic [23:0] r_asm,    n_asm;
    logic [11:0] r_idx,    n_idx;

    // sum with the 16-bit wrap fold applied when it leaves the window
    function automatic logic [31:0] f_step(input logic [31:0] prev, input logic [31:0] d,
                                           input logic signed [31:0] lo,
                                           input logic signed [31:0] hi);
        logic signed [31:0] s;
        logic [31:0]        dd;
        s  = $signed(prev + d);
        dd = d;
        if ((s < lo) || (hi < s)) begin
            if ((d == 32'd0) || d[31]) begin
                dd = d & sdbd_pkg::FOLD_LO_MASK;
            end else begin
                dd = d | sdbd_pkg::FOLD_HI_SET;
            end
        end
        return prev + dd;
    endfunction

    logic [2:0]  ph;
    logic [13:0] pos;
    logic [11:0] rate_full;
    logic [11:0] rate_m1;
    logic [31:0] d0, d1;
    logic [31:0] s0, s1;
    logic        last0, last1;
    logic [11:0] idx1;
    logic [13:0] fin_phase_sel;
    sdbd_pkg::t_result res0, res1;
    logic [1:0]  cnt;

    always_comb begin
        ph        = i_start ? sdbd_pkg::PH_HDR : r_phase;
        pos       = i_start ? 14'd0 : r_bcnt;
        rate_full = r_rate | {4'd0, i_byte};
        rate_m1   = r_rate - 12'd1;
        idx1      = r_idx + 12'd1;
        fin_phase_sel = pos + 14'd1;

        // delta candidates
        d0 = 32'd0;
        d1 = {{28{i_byte[3]}}, i_byte[3:0]};
        case (r_size)
            sdbd_pkg::SZ_NIBBLE: d0 = {{28{i_byte[7]}}, i_byte[7:4]};
            sdbd_pkg::SZ_BYTE:   d0 = {{24{i_byte[7]}}, i_byte};
            default:             d0 = {{16{r_asm[7]}}, r_asm[7:0], i_byte};
        endcase
        s0    = f_step(r_prev, d0, i_amp_min, i_amp_max);
        s1    = f_step(s0, d1, i_amp_min, i_amp_max);
        last0 = (r_idx == rate_m1);
        last1 = (idx1 == rate_m1);

        res0 = '0;
        res1 = '0;
        res0.channel_id   = r_chan;
        res0.rate_value   = r_rate;
        res0.status       = sdbd_pkg::STAT_OK;
        res1.channel_id   = r_chan;
        res1.rate_value   = r_rate;
        res1.status       = sdbd_pkg::STAT_OK;
        cnt = 2'd0;

        n_phase = r_phase;
        n_bcnt  = r_bcnt;
        n_glen  = r_glen;
        n_chan  = r_chan;
        n_rate  = r_rate;
        n_size  = r_size;
        n_prev  = r_prev;
        n_asm   = r_asm;
        n_idx   = r_idx;

        if (i_start) begin
            n_phase = sdbd_pkg::PH_HDR;
            n_bcnt  = 14'd0;
        end

        if (ph != sdbd_pkg::PH_IDLE) begin
            n_bcnt = pos + 14'd1;
            case (ph)
                sdbd_pkg::PH_HDR: begin
                    if (pos == sdbd_pkg::POS_CHAN_HI) begin
                        n_chan = {i_byte, 8'd0};
                    end else if (pos == sdbd_pkg::POS_CHAN_LO) begin
                        n_chan = r_chan | {8'd0, i_byte};
                    end else if (pos == sdbd_pkg::POS_FLAGS) begin
                        n_size = i_byte[6:4];
                        n_rate = {i_byte[3:0], 8'd0};
                        n_glen = {13'd0, i_byte[7]};
                    end else begin
                        n_rate = rate_full;
                        if ((r_size > sdbd_pkg::SZ_WORD) || (rate_full == 12'd0)) begin
                            res0.rate_value = rate_full;
                            res0.status     = sdbd_pkg::STAT_BAD;
                            cnt     = 2'd1;
                            n_phase = sdbd_pkg::PH_IDLE;
                        end else begin
                            case (r_size)
                                sdbd_pkg::SZ_NIBBLE:
                                    n_glen = r_glen + {3'd0, rate_full[11:1]} + 14'd8;
                                sdbd_pkg::SZ_BYTE:
                                    n_glen = r_glen + {2'd0, rate_full - 12'd1} + 14'd8;
                                default:
                                    n_glen = r_glen + {1'b0, rate_full - 12'd1, 1'b0}
                                             + 14'd8;
                            endcase
                            n_asm   = 24'd0;
                            n_idx   = 12'd0;
                            n_phase = sdbd_pkg::PH_FIRST;
                        end
                    end
                end
                sdbd_pkg::PH_FIRST: begin
                    if (pos < sdbd_pkg::POS_FIRST_LAST) begin
                        n_asm = {r_asm[15:0], i_byte};
                    end else begin
                        n_prev = {r_asm, i_byte};
                        res0.sample_value = {r_asm, i_byte};
                        res0.sample_index = 12'd0;
                        res0.last_sample  = (r_rate == 12'd1);
                        cnt   = 2'd1;
                        n_idx = 12'd1;
                        if (r_rate == 12'd1) begin
                            n_phase = (fin_phase_sel >= r_glen) ? sdbd_pkg::PH_IDLE
                                                                : sdbd_pkg::PH_SKIP;
                        end else begin
                            n_phase = sdbd_pkg::PH_DELTA;
                        end
                    end
                end
                sdbd_pkg::PH_DELTA: begin
                    if ((r_size == sdbd_pkg::SZ_NIBBLE) || (r_size == sdbd_pkg::SZ_BYTE)
                        || pos[0]) begin
                        res0.sample_value = s0;
                        res0.sample_index = r_idx;
                        res0.last_sample  = last0;
                        cnt    = 2'd1;
                        n_prev = s0;
                        n_idx  = idx1;
                        // second nibble only when the first did not end the group
                        if ((r_size == sdbd_pkg::SZ_NIBBLE) && !last0) begin
                            res1.sample_value = s1;
                            res1.sample_index = idx1;
                            res1.last_sample  = last1;
                            cnt    = 2'd2;
                            n_prev = s1;
                            n_idx  = idx1 + 12'd1;
                        end
                        if (last0 || ((r_size == sdbd_pkg::SZ_NIBBLE) && last1)) begin
                            n_phase = (fin_phase_sel >= r_glen) ? sdbd_pkg::PH_IDLE
                                                                : sdbd_pkg::PH_SKIP;
                        end
                    end else begin
                        n_asm = {16'd0, i_byte};
                    end
                end
                default: begin
                    if (fin_phase_sel >= r_glen) begin
                        n_phase = sdbd_pkg::PH_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sdbd_pkg::PH_IDLE;
            r_bcnt  <= 14'd0;
            r_glen  <= 14'd0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_bcnt  <= n_bcnt;
            r_glen  <= n_glen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_chan <= n_chan;
            r_rate <= n_rate;
            r_size <= n_size;
            r_prev <= n_prev;
            r_asm  <= n_asm;
            r_idx  <= n_idx;
        end
    end

    assign o_batch.res0 = res0;
    assign o_batch.res1 = res1;
    assign o_batch.cnt  = cnt;

endmodule

// ----- design/sdbd_out.sv -----
`timescale 1ns / 1ps

module sdbd_out (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  sdbd_pkg::t_batch     i_batch,
    output logic                 o_can_load,
    output logic                 o_valid,
    input  logic                 i_ready,
    output sdbd_pkg::t_result    o_res
);

    logic              r_out_valid;
    logic              r_spare_valid;
    sdbd_pkg::t_result r_out;
    sdbd_pkg::t_result r_spare;

    // a new batch fits when the spare slot is free and the output slot frees up
    assign o_can_load = !r_spare_valid && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_spare_valid <= 1'b0;
        end else if (i_load && (i_batch.cnt != 2'd0)) begin
            r_out_valid   <= 1'b1;
            r_spare_valid <= (i_batch.cnt == 2'd2);
        end else if (r_out_valid && i_ready) begin
            r_out_valid   <= r_spare_valid;
            r_spare_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && (i_batch.cnt != 2'd0)) begin
            r_out   <= i_batch.res0;
            r_spare <= i_batch.res1;
        end else if (r_out_valid && i_ready && r_spare_valid) begin
            r_out <= r_spare;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

// ----- design/seismic_delta_block_decoder.sv -----
`timescale 1ns / 1ps
// A byte sits in the input register from its accepting edge; once the decoder
// takes it, its first sample is registered in the output slot for the result port.
// Throughput: one byte per cycle while the output side can load; a nibble byte
// with two samples holds the next byte while the second drains via the spare slot.
// Reset (synchronous, active low): parser awaits a header, buffers empty,
// amp_min = -32768, amp_max = 32767.

module seismic_delta_block_decoder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input byte stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,   // [7:0] data_byte
    input  logic         i_s_tuser,   // [0] group_start
    // decoded samples
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [71:0]  o_m_tdata,   // [15:0] channel_id, [47:16] sample_value,
                                      // [59:48] rate_value, [71:60] sample_index
    output logic         o_m_tlast,   // last_sample
    output logic         o_m_tuser,   // [0] status
    // register writes
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    logic signed [31:0] r_amp_min;
    logic signed [31:0] r_amp_max;

    // input register: holds one byte until the decoder takes it
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_start;

    logic              fire;
    logic              can_load;
    sdbd_pkg::t_batch  batch;
    sdbd_pkg::t_result res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp_min <= -32'sd32768;
            r_amp_max <= 32'sd32767;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == 1'(sdbd_pkg::CFG_AMP_MIN)) begin
                r_amp_min <= i_cfg_data;
            end else begin
                r_amp_max <= i_cfg_data;
            end
        end
    end

    // decoder consumes the held byte when the output side can take two samples
    assign fire       = r_in_valid && can_load;
    assign o_s_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte  <= i_s_tdata;
            r_in_start <= i_s_tuser;
        end
    end

    sdbd_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_byte    (r_in_byte),
        .i_start   (r_in_start),
        .i_amp_min (r_amp_min),
        .i_amp_max (r_amp_max),
        .o_batch   (batch)
    );

    sdbd_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire),
        .i_batch    (batch),
        .o_can_load (can_load),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_res      (res)
    );

    assign o_m_tdata = {res.sample_index, res.rate_value, res.sample_value, res.channel_id};
    assign o_m_tlast = res.last_sample;
    assign o_m_tuser = res.status;

endmodule

// ----- verif/seismic_delta_block_decoder_tb.sv -----
`timescale 1ns / 1ps

module seismic_delta_block_decoder_tb;

    // Tracks the decoder state byte by byte and holds the samples still to come.
    class sample_scoreboard;
        logic [2:0]         phase;
        logic [13:0]        byte_cnt;
        logic [13:0]        grp_len;
        logic [15:0]        chan;
        logic [11:0]        rate;
        logic [2:0]         size;
        logic [31:0]        prev;
        logic [23:0]        asm_bytes;
        logic [11:0]        idx;
        logic signed [31:0] amp_lo;
        logic signed [31:0] amp_hi;
        sdbd_pkg::t_result  pending_samples[$];
        int                 n_errors;

        function new();
            amp_lo   = -32'sd32768;
            amp_hi   = 32'sd32767;
            phase    = sdbd_pkg::PH_IDLE;
            byte_cnt = '0;
            grp_len  = '0;
            chan     = '0;
            rate     = '0;
            size     = '0;
            prev     = '0;
            asm_bytes = '0;
            idx      = '0;
            n_errors = 0;
        endfunction

        task report(string msg);
            $display("%0t ns  MISMATCH: %s", $realtime, msg);
            n_errors++;
        endtask

        function void set_reg(logic sel, logic [31:0] v);
            if (sel == 1'(sdbd_pkg::CFG_AMP_MIN))
                amp_lo = v;
            else
                amp_hi = v;
        endfunction

        function void post_sample(logic [31:0] v, logic [11:0] at, logic last, logic stat);
            sdbd_pkg::t_result r;
            r.channel_id   = chan;
            r.sample_value = v;
            r.rate_value   = rate;
            r.sample_index = at;
            r.last_sample  = last;
            r.status       = stat;
            pending_samples.push_back(r);
        endfunction

        // add one delta (folded when the sum leaves the window); 1 on the last sample
        function bit apply_delta(logic [31:0] d);
            logic [31:0] s;
            bit          last;
            s = prev + d;
            if ($signed(s) < amp_lo || amp_hi < $signed(s)) begin
                if (d == 32'd0 || d[31])
                    d = d & sdbd_pkg::FOLD_LO_MASK;
                else
                    d = d | sdbd_pkg::FOLD_HI_SET;
            end
            prev = prev + d;
            last = (idx == rate - 12'd1);
            post_sample(prev, idx, last, sdbd_pkg::STAT_OK);
            idx = idx + 12'd1;
            return last;
        endfunction

        function void end_group();
            phase = (byte_cnt >= grp_len) ? sdbd_pkg::PH_IDLE : sdbd_pkg::PH_SKIP;
        endfunction

        function void decode_byte(logic [7:0] b, logic start);
            logic [13:0] pos;
            if (start) begin
                phase    = sdbd_pkg::PH_HDR;
                byte_cnt = '0;
            end
            if (phase == sdbd_pkg::PH_IDLE)
                return;
            pos      = byte_cnt;
            byte_cnt = byte_cnt + 14'd1;
            case (phase)
                sdbd_pkg::PH_HDR: begin
                    if (pos == sdbd_pkg::POS_CHAN_HI) begin
                        chan = {b, 8'h00};
                    end else if (pos == sdbd_pkg::POS_CHAN_LO) begin
                        chan[7:0] = b;
                    end else if (pos == sdbd_pkg::POS_FLAGS) begin
                        size    = b[6:4];
                        rate    = {b[3:0], 8'h00};
                        grp_len = {13'd0, b[7]};
                    end else begin
                        rate[7:0] = b;
                        if (size > sdbd_pkg::SZ_WORD || rate == 12'd0) begin
                            post_sample(32'd0, 12'd0, 1'b0, sdbd_pkg::STAT_BAD);
                            phase = sdbd_pkg::PH_IDLE;
                        end else begin
                            if (size != sdbd_pkg::SZ_NIBBLE)
                                grp_len = grp_len + 14'(size) * 14'(rate - 12'd1) + 14'd8;
                            else
                                grp_len = grp_len + 14'(rate >> 1) + 14'd8;
                            asm_bytes = '0;
                            idx       = '0;
                            phase     = sdbd_pkg::PH_FIRST;
                        end
                    end
                end
                sdbd_pkg::PH_FIRST: begin
                    if (pos < sdbd_pkg::POS_FIRST_LAST) begin
                        asm_bytes = {asm_bytes[15:0], b};
                    end else begin
                        prev = {asm_bytes, b};
                        post_sample(prev, 12'd0, rate == 12'd1, sdbd_pkg::STAT_OK);
                        idx = 12'd1;
                        if (rate == 12'd1)
                            end_group();
                        else
                            phase = sdbd_pkg::PH_DELTA;
                    end
                end
                sdbd_pkg::PH_DELTA: begin
                    case (size)
                        sdbd_pkg::SZ_NIBBLE: begin
                            // high nibble first; low nibble unused once the group ends
                            if (apply_delta({{28{b[7]}}, b[7:4]}))
                                end_group();
                            else if (apply_delta({{28{b[3]}}, b[3:0]}))
                                end_group();
                        end
                        sdbd_pkg::SZ_BYTE: begin
                            if (apply_delta({{24{b[7]}}, b}))
                                end_group();
                        end
                        default: begin
                            if (!pos[0])
                                asm_bytes = {16'h0000, b};
                            else if (apply_delta({{16{asm_bytes[7]}}, asm_bytes[7:0], b}))
                                end_group();
                        end
                    endcase
                end
                default: begin
                    if (byte_cnt >= grp_len)
                        phase = sdbd_pkg::PH_IDLE;
                end
            endcase
        endfunction

        task check_sample(logic [71:0] data, logic last, logic stat);
            sdbd_pkg::t_result e;
            string   diffs;
            if (pending_samples.size() == 0) begin
                report($sformatf("sample with none expected: tdata %h last %b user %b",
                                 data, last, stat));
                return;
            end
            e = pending_samples.pop_front();
            diffs = "";
            if (data[15:0] !== e.channel_id)
                diffs = {diffs, $sformatf(" channel %h exp %h", data[15:0], e.channel_id)};
            if (data[47:16] !== e.sample_value)
                diffs = {diffs, $sformatf(" value %h exp %h", data[47:16], e.sample_value)};
            if (data[59:48] !== e.rate_value)
                diffs = {diffs, $sformatf(" rate %h exp %h", data[59:48], e.rate_value)};
            if (data[71:60] !== e.sample_index)
                diffs = {diffs, $sformatf(" index %h exp %h", data[71:60], e.sample_index)};
            if (last !== e.last_sample)
                diffs = {diffs, $sformatf(" last %b exp %b", last, e.last_sample)};
            if (stat !== e.status)
                diffs = {diffs, $sformatf(" status %b exp %b", stat, e.status)};
            if (diffs != "")
                report({"sample field mismatch:", diffs});
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;    // [7:0] data_byte
    logic        i_s_tuser;    // [0] group_start
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [71:0] o_m_tdata;    // [15:0] channel_id, [47:16] sample_value,
                               // [59:48] rate_value, [71:60] sample_index
    logic        o_m_tlast;    // last_sample
    logic        o_m_tuser;    // [0] status
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [31:0] i_cfg_data;

    seismic_delta_block_decoder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    sample_scoreboard   sb;

    // stimulus knobs
    bit                 quiet;         // last part: no idling on either side
    int unsigned        gap_pct;       // sender idle chance per item, per group
    int unsigned        stall_pct;     // receiver stall chance per cycle
    int unsigned        stall_left;
    int unsigned        stall_cycle;
    int unsigned        group_items;   // items sent inside groups (junk not counted)
    int unsigned        group_no;
    int                 p;
    int                 k;
    logic signed [31:0] cur_lo;
    logic signed [31:0] cur_hi;
    logic signed [31:0] new_lo;
    logic signed [31:0] new_hi;
    logic [31:0]        center;
    logic [8:0]         intro_seq [24];   // {group_start, data_byte}

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // receiver: ready changes at the falling edge, stalls come in bursts of random length
    always @(negedge i_clk) begin
        stall_cycle <= stall_cycle + 1;
        if (stall_cycle % 64 == 0) begin
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 5;
                2:       stall_pct = 20;
                default: stall_pct = 40;
            endcase
        end
        if (stall_left > 0 && !quiet) begin
            i_m_tready = 1'b0;
            stall_left = stall_left - 1;
        end else begin
            i_m_tready = 1'b1;
            if (!quiet && stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
                stall_left = $urandom_range(1, 14);
        end
    end

    // result monitor: sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_sample(o_m_tdata, o_m_tlast, o_m_tuser);
    end

    // entered and left at a falling edge; valid stays high into the next item
    task automatic send_byte(logic [7:0] b, logic start);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = b;
        i_s_tuser  = start;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.decode_byte(b, start);
        @(negedge i_clk);
    endtask

    // stop sending, wait for every expected sample, then let the pipe settle
    task automatic drain_samples();
        i_s_tvalid = 1'b0;
        while (sb.pending_samples.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_reg(logic sel, logic [31:0] v);
        i_cfg_valid = 1'b1;
        i_cfg_index = sel;
        i_cfg_data  = v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(sel, v);
        @(negedge i_clk);
    endtask

    // One channel group with random content; mostly well formed, sometimes
    // a bad header, cut short, resynced mid-way or followed by stray bytes.
    task automatic send_random_group();
        logic [7:0]  bytes[$];
        logic [15:0] ch;
        logic [2:0]  sc;
        logic [11:0] rt;
        logic        pad;
        logic [31:0] first;
        int unsigned r;
        int unsigned len;
        int unsigned keep;
        int          mid;
        bit          bad;

        group_no++;
        if (!quiet && group_no % 25 == 0)
            drain_samples();    // sender holds off until every sample is out
        if (quiet) begin
            gap_pct = 0;
        end else begin
            case ($urandom_range(0, 3))
                0, 1:    gap_pct = 0;
                2:       gap_pct = 10;
                default: gap_pct = 25;
            endcase
        end

        r = $urandom_range(0, 9);
        if (r < 3)
            sc = sdbd_pkg::SZ_NIBBLE;
        else if (r < 6)
            sc = sdbd_pkg::SZ_BYTE;
        else if (r < 9)
            sc = sdbd_pkg::SZ_WORD;
        else
            sc = 3'($urandom_range(3, 7));
        r = $urandom_range(0, 79);
        if (r == 0)
            rt = 12'($urandom_range(60, 300));
        else if (r < 8)
            rt = 12'($urandom_range(0, 3));
        else
            rt = 12'($urandom_range(1, 16));
        pad = 1'($urandom_range(0, 1));
        ch  = 16'($urandom_range(0, 65535));
        bad = (sc > sdbd_pkg::SZ_WORD) || (rt == 12'd0);

        bytes.push_back(ch[15:8]);
        bytes.push_back(ch[7:0]);
        bytes.push_back({pad, sc, rt[11:8]});
        bytes.push_back(rt[7:0]);
        if (!bad) begin
            // first sample near the window edges half the time so both folded
            // and plain additions show up
            case ($urandom_range(0, 3))
                0:       first = $urandom;
                1:       first = cur_hi - $urandom_range(0, 40);
                2:       first = cur_lo + $urandom_range(0, 40);
                default: first = $urandom_range(0, 200) - 100;
            endcase
            bytes.push_back(first[31:24]);
            bytes.push_back(first[23:16]);
            bytes.push_back(first[15:8]);
            bytes.push_back(first[7:0]);
            if (sc != sdbd_pkg::SZ_NIBBLE)
                len = sc * (rt - 1) + 8;
            else
                len = (rt >> 1) + 8;
            len = len + pad;
            while (bytes.size() < len)
                bytes.push_back(8'($urandom_range(0, 255)));
        end

        keep = bytes.size();
        if ($urandom_range(0, 9) == 0)
            keep = $urandom_range(1, bytes.size());
        mid = -1;
        if (keep > 1 && $urandom_range(0, 19) == 0)
            mid = $urandom_range(1, keep - 1);
        for (int i = 0; i < keep; i++)
            send_byte(bytes[i], i == 0 || i == mid);
        group_items = group_items + keep;

        if (bad || $urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 3))
                send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = 1'b0;
        i_m_tready  = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data  = '0;
        quiet       = 1'b0;
        gap_pct     = 0;
        stall_pct   = 0;
        stall_left  = 0;
        stall_cycle = 0;
        group_items = 0;
        group_no    = 0;
        cur_lo      = -32'sd32768;
        cur_hi      = 32'sd32767;
        sb          = new();

        // directed part, reset window
        intro_seq = '{
            9'h0A5,                             // stray byte, no group start
            9'h1FF, 9'h0FF, 9'h07F, 9'h0FF,     // bad header: size 7, rate 4095
            9'h100, 9'h000, 9'h000, 9'h000,     // bad header: rate 0
            9'h180, 9'h001, 9'h090, 9'h002,     // byte deltas, pad, rate 2 ...
            9'h07F, 9'h0FF,                     // ... cut off in the first sample
            9'h1FF, 9'h0FF, 9'h000, 9'h003,     // resync: nibble group, rate 3
            9'h080, 9'h000, 9'h000, 9'h000,     // first sample = most negative
            9'h07F                              // +7 and -1, both folded
        };

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (k = 0; k < 24; k++)
            send_byte(intro_seq[k][7:0], intro_seq[k][8]);
        group_items = 24;

        // random part, one window setting per phase
        for (p = 0; p < 6; p++) begin
            if (p > 0) begin
                drain_samples();
                case (p)
                    1: begin    // widest window: nothing folds
                        new_lo = 32'sh80000000;
                        new_hi = 32'sh7FFFFFFF;
                    end
                    2: begin    // inverted extremes: everything folds
                        new_lo = 32'sh7FFFFFFF;
                        new_hi = 32'sh80000000;
                    end
                    3: begin    // single point window
                        new_lo = 32'sd0;
                        new_hi = 32'sd0;
                    end
                    4: begin    // narrow window somewhere random
                        center = $urandom;
                        new_lo = center - $urandom_range(0, 5000);
                        new_hi = center + $urandom_range(0, 5000);
                    end
                    default: begin
                        new_lo = -32'sd32768;
                        new_hi = 32'sd32767;
                    end
                endcase
                write_reg(1'(sdbd_pkg::CFG_AMP_MIN), new_lo);
                write_reg(1'(sdbd_pkg::CFG_AMP_MAX), new_hi);
                i_cfg_valid = 1'b0;
                cur_lo = new_lo;
                cur_hi = new_hi;
            end
            quiet = (p == 5);
            while (group_items < 24 + (p + 1) * 255)
                send_random_group();
        end

        drain_samples();
        repeat (20) @(posedge i_clk);
        if (sb.pending_samples.size() != 0)
            sb.report($sformatf("%0d expected samples never came",
                                sb.pending_samples.size()));
        if (sb.n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // hard stop, well beyond the slowest legal run
    initial begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
